// ----- rtl/core/afcl_pkg.sv -----
`default_nettype none

package afcl_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IP_W = 32;
  localparam int MAC_W = 48;
  localparam int ENTRY_W = IP_W + MAC_W;

  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY = 16'd2;

  typedef enum logic [2:0] {
    ST_REQUEST = 3'd0,
    ST_ADDED   = 3'd1,
    ST_UPDATED = 3'd2,
    ST_FULL    = 3'd3,
    ST_NOT_ARP = 3'd4,
    ST_BAD_OP  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_CHK,
    SEL_CNT
  } slot_sel_t;

  typedef struct packed {
    logic [15:0]      ether_type;
    logic [15:0]      arp_opcode;
    logic [IP_W-1:0]  peer_ip;
    logic [MAC_W-1:0] peer_mac;
  } in_req_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] entry_slot;
    logic [4:0] fill_count;
  } out_res_t;

  typedef struct packed {
    logic      capture;
    logic      scan_step;
    logic      set_res;
    status_t   res_status;
    slot_sel_t res_sel;
    logic      wr;
    logic      load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_arp;
    logic op_req;
    logic op_reply;
    logic cnt_zero;
    logic hit;
    logic last;
    logic full;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/afcl_ram.sv -----
`default_nettype none

module afcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/afcl_ctrl.sv -----
`default_nettype none

module afcl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire afcl_pkg::dp_sts_t sts,
  output afcl_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_SCAN,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    cmd            = '0;
    cmd.res_status = afcl_pkg::ST_REQUEST;
    cmd.res_sel    = afcl_pkg::SEL_ZERO;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        cmd.scan_step = 1'b1;
        cmd.set_res   = 1'b1;
        if (!sts.is_arp) begin
          cmd.res_status = afcl_pkg::ST_NOT_ARP;
          state_nxt      = S_FINISH;
        end else if (sts.op_req) begin
          cmd.res_status = afcl_pkg::ST_REQUEST;
          state_nxt      = S_FINISH;
        end else if (sts.op_reply) begin
          if (sts.cnt_zero) begin
            cmd.res_status = afcl_pkg::ST_ADDED;
            cmd.res_sel    = afcl_pkg::SEL_CNT;
            state_nxt      = S_WRITE;
          end else begin
            cmd.set_res = 1'b0;
            state_nxt   = S_SCAN;
          end
        end else begin
          cmd.res_status = afcl_pkg::ST_BAD_OP;
          state_nxt      = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = afcl_pkg::ST_UPDATED;
          cmd.res_sel    = afcl_pkg::SEL_CHK;
          state_nxt      = S_WRITE;
        end else if (sts.last) begin
          cmd.set_res = 1'b1;
          if (sts.full) begin
            cmd.res_status = afcl_pkg::ST_FULL;
            state_nxt      = S_FINISH;
          end else begin
            cmd.res_status = afcl_pkg::ST_ADDED;
            cmd.res_sel    = afcl_pkg::SEL_CNT;
            state_nxt      = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_classify: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CLASSIFY))
    else $error("accepted request did not move to classify");

  a_write_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> (state_r == S_FINISH))
    else $error("table write not followed by finish");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while still pending");

  a_wr_only_learn: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> $past(state_r == S_SCAN || state_r == S_CLASSIFY))
    else $error("table write outside a learn sequence");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/afcl_dp.sv -----
`default_nettype none

module afcl_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire afcl_pkg::in_req_t in_data,
  input  wire afcl_pkg::dp_cmd_t cmd,
  output afcl_pkg::dp_sts_t      sts,
  output afcl_pkg::out_res_t     out_data
);

  afcl_pkg::in_req_t  req_r, req_nxt;
  afcl_pkg::status_t  res_status_r, res_status_nxt;
  afcl_pkg::out_res_t out_r, out_nxt;

  logic [afcl_pkg::IDX_W-1:0]   scan_r, scan_nxt;
  logic [afcl_pkg::IDX_W-1:0]   chk_r, chk_nxt;
  logic [afcl_pkg::IDX_W-1:0]   res_slot_r, res_slot_nxt;
  logic [afcl_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [afcl_pkg::ENTRY_W-1:0] rd_data;
  logic [afcl_pkg::IP_W-1:0]    rd_ip;

  afcl_ram #(
    .WIDTH(afcl_pkg::ENTRY_W),
    .DEPTH(afcl_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.wr),
    .wr_addr (res_slot_r),
    .wr_data ({req_r.peer_ip, req_r.peer_mac}),
    .rd_addr (scan_r),
    .rd_data (rd_data)
  );

  assign rd_ip = rd_data[afcl_pkg::ENTRY_W-1:afcl_pkg::MAC_W];

  always_comb begin
    sts.is_arp   = (req_r.ether_type == afcl_pkg::ETYPE_ARP);
    sts.op_req   = (req_r.arp_opcode == afcl_pkg::OP_REQUEST);
    sts.op_reply = (req_r.arp_opcode == afcl_pkg::OP_REPLY);
    sts.cnt_zero = (cnt_r == '0);
    // rd_data holds the entry at chk_r, read in the previous cycle
    sts.hit      = (rd_ip == req_r.peer_ip);
    sts.last     = ((afcl_pkg::CNT_W'(chk_r) + afcl_pkg::CNT_W'(1)) == cnt_r);
    sts.full     = (cnt_r == afcl_pkg::CNT_W'(afcl_pkg::TABLE_ENTRIES));
  end

  always_comb begin
    req_nxt        = req_r;
    scan_nxt       = scan_r;
    chk_nxt        = chk_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    cnt_nxt        = cnt_r;
    out_nxt        = out_r;
    if (cmd.capture) begin
      req_nxt  = in_data;
      scan_nxt = '0;
    end
    if (cmd.scan_step) begin
      scan_nxt = scan_r + afcl_pkg::IDX_W'(1);
      chk_nxt  = scan_r;
    end
    if (cmd.set_res) begin
      res_status_nxt = cmd.res_status;
      case (cmd.res_sel)
        afcl_pkg::SEL_CHK: res_slot_nxt = chk_r;
        afcl_pkg::SEL_CNT: res_slot_nxt = afcl_pkg::IDX_W'(cnt_r);
        default:           res_slot_nxt = '0;
      endcase
    end
    if (cmd.wr && (res_status_r == afcl_pkg::ST_ADDED)) begin
      cnt_nxt = cnt_r + afcl_pkg::CNT_W'(1);
    end
    if (cmd.load_out) begin
      out_nxt.status     = res_status_r;
      out_nxt.entry_slot = 4'(res_slot_r);
      out_nxt.fill_count = 5'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    scan_r       <= scan_nxt;
    chk_r        <= chk_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_r        <= out_nxt;
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= afcl_pkg::CNT_W'(afcl_pkg::TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + afcl_pkg::CNT_W'(1)))
    else $error("fill count moved by other than one");

  a_add_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr && res_status_r == afcl_pkg::ST_ADDED) |->
      (afcl_pkg::CNT_W'(res_slot_r) == cnt_r))
    else $error("append not at the fill count");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/arp_frame_check_and_learn_unit.sv -----
`default_nettype none

// ARP frame check and learn unit. Each request carries the decoded header of
// one received frame; exactly one result comes back per request, in order.
// Non-ARP frames, ARP requests and bad opcodes go from classify straight to
// finish. A reply searches the IP table one entry per cycle through the table
// RAM's registered read port, then writes the entry: the matching slot on a
// hit, or the slot at the fill count on a miss. A miss on a full table skips
// the write. A new request is taken in the cycle after the result is loaded
// into the output register, even while that result is still stalled. The
// table needs no clearing after reset: only entries below the fill count are
// ever compared.
module arp_frame_check_and_learn_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire afcl_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output afcl_pkg::out_res_t      out_data
);

  afcl_pkg::dp_cmd_t cmd;
  afcl_pkg::dp_sts_t sts;

  afcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  afcl_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
